>>> sv/positional_list_insert_erase_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional list unit
// Clocked, reset-qualified property checks used by the controller.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_ERASE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_ERASE_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define PLUE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define PLUE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

>>> sv/plue_pkg.sv
// ---------------------------------------------------------------------------
// Positional list package
// Sizes, codes and shared types for the positional list unit.
// ---------------------------------------------------------------------------
`default_nettype none

package plue_pkg;

  localparam int DEPTH     = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LEAF_N    = 8;
  localparam int GROUPS    = (DEPTH + LEAF_N - 1) / LEAF_N;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE,
    S_OUT
  } state_t;

  // Command broadcast from the controller to the cell row and read tree
  typedef struct packed {
    logic             ins;
    logic             era;
    logic             rd;
    logic [POS_W-1:0] pos;
    logic             cap_leaf;
    logic             cap_root;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/plue_cell.sv
// ---------------------------------------------------------------------------
// Positional list cell
// One list entry; takes from its left or right neighbour on insert or erase.
// ---------------------------------------------------------------------------
`default_nettype none

module plue_cell (
  input  logic              clk,
  input  plue_pkg::cmd_t    cmd,
  input  plue_pkg::cnt_t    idx,
  input  plue_pkg::word_t   new_val,
  input  plue_pkg::word_t   left_val,
  input  plue_pkg::word_t   right_val,
  output plue_pkg::word_t   val,
  output plue_pkg::word_t   rd_val
);
  import plue_pkg::*;

  word_t            val_r;
  word_t            val_nxt;
  logic [CMP_W-1:0] my_idx;
  logic [CMP_W-1:0] req_pos;

  assign my_idx  = CMP_W'(idx);
  assign req_pos = CMP_W'(cmd.pos);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (my_idx > req_pos) begin
        val_nxt = left_val;
      end else if (my_idx == req_pos) begin
        val_nxt = new_val;
      end
    end else if (cmd.era) begin
      // pull the right neighbour down over the erased slot
      if (my_idx >= req_pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = (cmd.rd && (my_idx == req_pos)) ? val_r : '0;

endmodule

`default_nettype wire

>>> sv/plue_read_tree.sv
// ---------------------------------------------------------------------------
// Positional list read tree
// Two-level registered OR tree that gathers the one selected cell value.
// ---------------------------------------------------------------------------
`default_nettype none

module plue_read_tree (
  input  logic            clk,
  input  plue_pkg::cmd_t  cmd,
  input  plue_pkg::word_t leaf_val [plue_pkg::DEPTH],
  output plue_pkg::word_t root_val
);
  import plue_pkg::*;

  word_t grp_nxt [GROUPS];
  word_t grp_r   [GROUPS];
  word_t root_nxt;
  word_t root_r;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < LEAF_N; k++) begin
        if (g * LEAF_N + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | leaf_val[g * LEAF_N + k];
        end
      end
    end
  end

  always_comb begin
    root_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      root_nxt = root_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_leaf) begin
      grp_r <= grp_nxt;
    end
    if (cmd.cap_root) begin
      root_r <= root_nxt;
    end
  end

  assign root_val = root_r;

endmodule

`default_nettype wire

>>> sv/plue_ctrl.sv
// ---------------------------------------------------------------------------
// Positional list controller
// Request sequencer, status decision and entry count.
// ---------------------------------------------------------------------------
`default_nettype none
`include "positional_list_insert_erase_unit_assert.svh"

module plue_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [plue_pkg::POS_W-1:0]      in_position,
  input  plue_pkg::word_t                 in_item_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [plue_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic                            out_is_empty,
  output logic [1:0]                      out_status,
  output plue_pkg::cmd_t                  cmd,
  output plue_pkg::word_t                 new_val
);
  import plue_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  cnt_t             count_r;
  cnt_t             count_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic [1:0]       req_mode_r;
  logic [POS_W-1:0] req_pos_r;
  word_t            req_value_r;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             in_take;

  assign cnt_ext = CMP_W'(count_r);
  assign pos_ext = CMP_W'(req_pos_r);
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_mode_r  <= in_mode;
      req_pos_r   <= in_position;
      req_value_r <= in_item_value;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    status_nxt   = status_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.pos      = req_pos_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt   = ST_OK;
        cmd.cap_leaf = 1'b1;
        case (req_mode_r)
          MODE_INSERT: begin
            if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              cmd.ins   = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          MODE_ERASE: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              cmd.era   = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          MODE_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              cmd.rd = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        cmd.cap_root = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign new_val         = req_value_r;
  assign out_entry_count = CNT_OUT_W'(count_r);
  assign out_is_empty    = (count_r == '0);
  assign out_status      = status_r;

  `PLUE_ASSERT_NEXT(a_ins_grows, clk, rst_n, cmd.ins, count_r == CNT_W'($past(count_r) + 1'b1))
  `PLUE_ASSERT_NEXT(a_era_shrinks, clk, rst_n, cmd.era, count_r == CNT_W'($past(count_r) - 1'b1))
  `PLUE_ASSERT_NOW(a_one_at_a_time, clk, rst_n, out_valid, in_stall)
  `PLUE_ASSERT_NOW(a_full_means_full, clk, rst_n, out_valid && (status_r == ST_FULL), count_r == CNT_W'(DEPTH))

endmodule

`default_nettype wire

>>> sv/positional_list_insert_erase_unit.sv
// Sequencing: one transaction at a time; a new request is not accepted until
//   the result of the last one has been handed over, as set by the four-step
//   sequencer (accept, update, gather, hand over).
// Reset: rst_n, synchronous, active low; clears the entry count, status and
//   sequencer. Entry storage is not reset and is never read before written.
// ---------------------------------------------------------------------------
// Positional list insert/erase unit
// Ordered list of signed words held in a row of cells. Insert shifts the
// tail up one cell, erase shifts it down one, read picks one cell out.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_erase_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_mode,
  input  logic [plue_pkg::POS_W-1:0]            in_position,
  input  logic signed [plue_pkg::DATA_W-1:0]    in_item_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [plue_pkg::DATA_W-1:0]    out_read_value,
  output logic [plue_pkg::CNT_OUT_W-1:0]        out_entry_count,
  output logic                                  out_is_empty,
  output logic [1:0]                            out_status
);
  import plue_pkg::*;

  cmd_t  cmd;
  word_t new_val;
  word_t cell_val [DEPTH];
  word_t cell_rd  [DEPTH];
  word_t root_val;

  // Sequencer: hold one transaction at a time, decide its status, update the
  // count and broadcast the shift or read command to the cell row.
  plue_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_item_value   (word_t'(in_item_value)),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status),
    .cmd             (cmd),
    .new_val         (new_val)
  );

  // Row of cells. Each cell sees its left and right neighbour; the first
  // cell never takes from the left and the last keeps its own value on erase,
  // so tie those ends off to something harmless.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_in;
    word_t right_in;

    if (g == 0) begin : g_first
      assign left_in = new_val;
    end else begin : g_mid_l
      assign left_in = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_in = cell_val[g];
    end else begin : g_mid_r
      assign right_in = cell_val[g+1];
    end

    plue_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (CNT_W'(g)),
      .new_val   (new_val),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[g]),
      .rd_val    (cell_rd[g])
    );
  end

  // Gather the selected cell: only one cell drives a non-zero word on a read,
  // and none on any other request, so the OR tree yields the read value or 0.
  plue_read_tree u_read_tree (
    .clk      (clk),
    .cmd      (cmd),
    .leaf_val (cell_rd),
    .root_val (root_val)
  );

  assign out_read_value = $signed(root_val);

endmodule

`default_nettype wire
